@@ rtl/wfm_pkg.sv @@
// ----------------------------------------------------------------------------
// Window function multiplier package
// Shared types, register indexes, window codes and the quarter-wave cosine
// table used by the window function multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package wfm_pkg;

  // Fixed field widths.
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned FL_W    = 13;
  localparam int unsigned PHASE_W = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned OUT_W   = 19;

  // Window value is Q4.14, held in 18 signed bits.
  localparam int unsigned WIN_W    = 18;
  localparam int unsigned COS_W    = 16;
  localparam int unsigned FRAC     = 14;
  localparam int          ONE_Q14  = 16384;
  localparam int          OUT_MAX  = 262143;
  localparam int          OUT_MIN  = -262144;

  // Cosine table geometry.
  localparam int unsigned COS_TABLE_BITS = 10;
  localparam int unsigned QUARTER        = 1 << (COS_TABLE_BITS - 2);
  localparam int unsigned ROM_IDX_W      = COS_TABLE_BITS - 1;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // Register indexes of the configuration port.
  typedef enum logic [IDX_W-1:0] {
    REG_WINDOW_KIND  = 2'd0,
    REG_FRAME_LENGTH = 2'd1,
    REG_PHASE_STEP   = 2'd2
  } reg_idx_e;

  // Window codes; unlisted codes act as rectangular.
  typedef enum logic [KIND_W-1:0] {
    WIN_RECT     = 3'd0,
    WIN_HANN     = 3'd1,
    WIN_HAMMING  = 3'd2,
    WIN_BLACKMAN = 3'd3,
    WIN_FLATTOP  = 3'd4
  } win_kind_e;

  // Per-item side information that travels with the sample.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               last;
  } item_meta_t;

  typedef logic [FRAC:0] cos_rom_t [QUARTER+1];

  // Divisors (2k-1)(2k) of the Taylor series terms.
  localparam longint unsigned TAYLOR_DIV [1:12] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  // Builds the quarter-wave table at elaboration with a Q2.30 Taylor series.
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t    rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      v;
    for (int i = 0; i <= int'(QUARTER); i++) begin
      x    = (PI_HALF_Q30 * 64'(i)) / QUARTER;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int k = 1; k <= 12; k++) begin
        term = (term * x2) >> 30;
        term = term / TAYLOR_DIV[k];
        if ((k & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      v = (sum > 0) ? longint'((64'(sum) + 64'd32768) >> 16) : 64'sd0;
      if (v > ONE_Q14) begin
        v = ONE_Q14;
      end
      rom[i] = (FRAC+1)'(v);
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

  // Full-turn cosine from the quarter-wave table by quadrant symmetry.
  function automatic logic signed [COS_W-1:0] cos_lookup(
    input logic [COS_TABLE_BITS-1:0] idx
  );
    logic [1:0]           quad;
    logic [ROM_IDX_W-1:0] off;
    logic [ROM_IDX_W-1:0] mirror;
    logic signed [COS_W-1:0] pos_val;
    logic signed [COS_W-1:0] mir_val;
    quad    = idx[COS_TABLE_BITS-1 -: 2];
    off     = {1'b0, idx[COS_TABLE_BITS-3:0]};
    mirror  = ROM_IDX_W'(QUARTER) - off;
    pos_val = signed'({1'b0, COS_ROM[off]});
    mir_val = signed'({1'b0, COS_ROM[mirror]});
    case (quad)
      2'd0:    return pos_val;
      2'd1:    return -mir_val;
      2'd2:    return -pos_val;
      default: return mir_val;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ rtl/wfm_front.sv @@
// ----------------------------------------------------------------------------
// Window function multiplier front end
// Accepts samples, tracks the position and phase within the frame, flags the
// last sample of a frame and pushes each item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wfm_front #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_FRAME   = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [wfm_pkg::FL_W-1:0]        frame_length_i,
  input  wire logic [wfm_pkg::PHASE_W-1:0]     phase_step_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]   sample_in_i,
  input  wire logic                            q_full_i,
  output logic                                 q_push_o,
  output logic signed [SAMPLE_BITS-1:0]        q_sample_o,
  output wfm_pkg::item_meta_t                  q_meta_o
);

  import wfm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME);
  localparam int unsigned NW    = (CNT_W + 1 > FL_W) ? CNT_W + 1 : FL_W;
  localparam logic [NW-1:0] MAX_LEN = NW'(MAX_FRAME);

  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [NW-1:0]      len_ext;
  logic [NW-1:0]      n_eff;
  logic [NW-1:0]      limit;
  logic               last;
  logic               accept;

  // Effective frame length: zero acts as one, oversize clamps to the maximum.
  always_comb begin
    len_ext = NW'(frame_length_i);
    if (len_ext == '0) begin
      n_eff = NW'(1);
    end else if (len_ext > MAX_LEN) begin
      n_eff = MAX_LEN;
    end else begin
      n_eff = len_ext;
    end
    limit = n_eff - NW'(1);
    last  = NW'(pos_q) >= limit;
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept;
  assign q_sample_o = sample_in_i;

  always_comb begin
    q_meta_o.phase = phase_q;
    q_meta_o.last  = last;
  end

  // Position and phase restart after the last item of a frame.
  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    if (accept) begin
      if (last) begin
        pos_d   = '0;
        phase_d = '0;
      end else begin
        pos_d   = pos_q + CNT_W'(1);
        phase_d = phase_q + phase_step_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= '0;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/wfm_queue.sv @@
// ----------------------------------------------------------------------------
// Window function multiplier item queue
// Two-entry first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wfm_queue #(
  parameter int unsigned DATA_W = 49
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output logic [DATA_W-1:0]      data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic              wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/wfm_back.sv @@
// ----------------------------------------------------------------------------
// Window function multiplier back end
// Pipeline that looks up the harmonic cosines, forms the window value,
// multiplies the sample and rounds and saturates the result.
// ----------------------------------------------------------------------------
`default_nettype none

module wfm_back #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [wfm_pkg::KIND_W-1:0]        window_kind_i,
  input  wire logic                              q_valid_i,
  input  wire logic signed [SAMPLE_BITS-1:0]     q_sample_i,
  input  wire wfm_pkg::item_meta_t               q_meta_i,
  output logic                                   q_pop_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [wfm_pkg::OUT_W-1:0]       windowed_sample_o,
  output logic                                   frame_end_o
);

  import wfm_pkg::*;

  localparam int unsigned COEF_W = 17;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned PW     = SAMPLE_BITS + WIN_W;
  localparam int unsigned YW     = PW + 1;
  localparam int unsigned SW     = (YW > OUT_W + 1) ? YW : OUT_W + 1;
  localparam logic signed [SW-1:0] SAT_HI = SW'(OUT_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(OUT_MIN);
  localparam int unsigned HALF_LSB = 1 << (FRAC - 1);

  typedef struct packed {
    logic                     rect;
    logic signed [COEF_W-1:0] a0;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] c3;
    logic signed [COEF_W-1:0] c4;
  } win_coef_t;

  // Stage registers.
  logic                          v1_q, v2_q, v3_q, v4_q;
  logic                          last1_q, last2_q, last3_q, last4_q;
  logic signed [SAMPLE_BITS-1:0] smp1_q, smp2_q, smp3_q;
  logic signed [COS_W-1:0]       cos_q [4];
  logic signed [PROD_W-1:0]      prod_q [4];
  logic signed [WIN_W-1:0]       win_q;
  logic signed [PW-1:0]          mul_q;
  logic                          out_valid_q;
  logic signed [OUT_W-1:0]       y_q;
  logic                          fe_q;

  logic                          adv;
  logic [PHASE_W-1:0]            ph2, ph3, ph4;
  logic signed [COS_W-1:0]       cos_d [4];
  win_coef_t                     coef;
  logic signed [PROD_W-1:0]      prod_d [4];
  logic signed [PROD_W-1:0]      acc;
  logic signed [PROD_W-1:0]      acc_rnd;
  logic signed [PROD_W-1:0]      win_sum;
  logic signed [WIN_W-1:0]       win_d;
  logic signed [PW-1:0]          mul_d;
  logic signed [YW-1:0]          rnd_sum;
  logic signed [YW-1:0]          y_shift;
  logic signed [SW-1:0]          y_ext;
  logic signed [OUT_W-1:0]       y_d;

  // The whole pipeline moves when the output register can take an item.
  assign adv     = !out_valid_q || out_ready_i;
  assign q_pop_o = adv && q_valid_i;

  // Stage 1: harmonic phases and quarter-wave lookups.
  always_comb begin
    ph2      = q_meta_i.phase << 1;
    ph3      = q_meta_i.phase + ph2;
    ph4      = q_meta_i.phase << 2;
    cos_d[0] = cos_lookup(q_meta_i.phase[PHASE_W-1 -: COS_TABLE_BITS]);
    cos_d[1] = cos_lookup(ph2[PHASE_W-1 -: COS_TABLE_BITS]);
    cos_d[2] = cos_lookup(ph3[PHASE_W-1 -: COS_TABLE_BITS]);
    cos_d[3] = cos_lookup(ph4[PHASE_W-1 -: COS_TABLE_BITS]);
  end

  // Window coefficients in Q14.
  always_comb begin
    coef = '{rect: 1'b1, a0: COEF_W'(ONE_Q14), default: '0};
    unique case (window_kind_i)
      WIN_HANN: begin
        coef = '{rect: 1'b0, a0: 17'sd8192, c1: -17'sd8192, default: '0};
      end
      WIN_HAMMING: begin
        coef = '{rect: 1'b0, a0: 17'sd8847, c1: -17'sd7537, default: '0};
      end
      WIN_BLACKMAN: begin
        coef = '{rect: 1'b0, a0: 17'sd6881, c1: -17'sd8192, c2: 17'sd1311,
                 default: '0};
      end
      WIN_FLATTOP: begin
        coef = '{rect: 1'b0, a0: 17'sd16384, c1: -17'sd31621, c2: 17'sd21135,
                 c3: -17'sd6357, c4: 17'sd524};
      end
      default: begin
        coef = '{rect: 1'b1, a0: COEF_W'(ONE_Q14), default: '0};
      end
    endcase
  end

  // Stage 2: coefficient times cosine, one lane per harmonic.
  always_comb begin
    prod_d[0] = coef.c1 * cos_q[0];
    prod_d[1] = coef.c2 * cos_q[1];
    prod_d[2] = coef.c3 * cos_q[2];
    prod_d[3] = coef.c4 * cos_q[3];
  end

  // Stage 3: sum of the terms, rounded half up to Q14, plus the constant term.
  // The rounding offset is kept signed so the shift stays arithmetic.
  always_comb begin
    acc     = prod_q[0] + prod_q[1] + prod_q[2] + prod_q[3];
    acc_rnd = (acc + $signed(PROD_W'(HALF_LSB))) >>> FRAC;
    win_sum = PROD_W'(coef.a0) + acc_rnd;
    win_d   = coef.rect ? WIN_W'(ONE_Q14) : win_sum[WIN_W-1:0];
  end

  // Stage 4: sample times window.
  assign mul_d = smp3_q * win_q;

  // Output stage: round half up, then saturate to the output range.
  always_comb begin
    rnd_sum = YW'(mul_q) + YW'(HALF_LSB);
    y_shift = rnd_sum >>> FRAC;
    y_ext   = SW'(y_shift);
    if (y_ext > SAT_HI) begin
      y_d = OUT_W'(SAT_HI);
    end else if (y_ext < SAT_LO) begin
      y_d = OUT_W'(SAT_LO);
    end else begin
      y_d = y_ext[OUT_W-1:0];
    end
  end

  // Stage valid bits and the output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= q_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      smp1_q  <= q_sample_i;
      last1_q <= q_meta_i.last;
      cos_q   <= cos_d;
      smp2_q  <= smp1_q;
      last2_q <= last1_q;
      prod_q  <= prod_d;
      smp3_q  <= smp2_q;
      last3_q <= last2_q;
      win_q   <= win_d;
      last4_q <= last3_q;
      mul_q   <= mul_d;
      y_q     <= y_d;
      fe_q    <= last4_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign windowed_sample_o = y_q;
  assign frame_end_o       = fe_q;

endmodule

`default_nettype wire

@@ rtl/window_function_multiplier.sv @@
// ----------------------------------------------------------------------------
// Window function multiplier
// Multiplies each sample by a rectangular, Hann, Hamming, Blackman or
// flat-top window value at its position in the frame.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_ready_o   sample_in_i
//   out      output     out_valid_o/out_ready_i windowed_sample_o, frame_end_o
//   cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// One item per cycle sustained while results are taken; the back-end pipeline has
// five register stages, stage 1 to stage 4 and the output register.
// A two-entry queue sits between the front end and the back end; the back
// end stalls as a whole while the output register holds an untaken result.
// Reset clears position and phase and loads the default configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module window_function_multiplier #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_FRAME   = 4096
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [wfm_pkg::IDX_W-1:0]         cfg_index_i,
  input  wire logic [wfm_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]     sample_in_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [wfm_pkg::OUT_W-1:0]       windowed_sample_o,
  output logic                                   frame_end_o
);

  import wfm_pkg::*;

  localparam int unsigned Q_W = SAMPLE_BITS + $bits(item_meta_t);

  logic [KIND_W-1:0]             window_kind_q;
  logic [FL_W-1:0]               frame_length_q;
  logic [PHASE_W-1:0]            phase_step_q;

  logic                          q_push, q_full, q_pop, q_valid;
  logic signed [SAMPLE_BITS-1:0] f_sample;
  item_meta_t                    f_meta;
  logic [Q_W-1:0]                q_wdata, q_rdata;
  logic signed [SAMPLE_BITS-1:0] b_sample;
  item_meta_t                    b_meta;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_kind_q  <= WIN_HANN;
      frame_length_q <= FL_W'(512);
      phase_step_q   <= PHASE_W'(8388608);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_KIND:  window_kind_q  <= cfg_data_i[KIND_W-1:0];
        REG_FRAME_LENGTH: frame_length_q <= cfg_data_i[FL_W-1:0];
        REG_PHASE_STEP:   phase_step_q   <= cfg_data_i[PHASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wfm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_FRAME   (MAX_FRAME)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_length_i (frame_length_q),
    .phase_step_i   (phase_step_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_in_i    (sample_in_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_sample_o     (f_sample),
    .q_meta_o       (f_meta)
  );

  assign q_wdata = {f_sample, f_meta};

  wfm_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  assign b_sample = q_rdata[Q_W-1 -: SAMPLE_BITS];
  assign b_meta   = q_rdata[$bits(item_meta_t)-1:0];

  wfm_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .window_kind_i     (window_kind_q),
    .q_valid_i         (q_valid),
    .q_sample_i        (b_sample),
    .q_meta_i          (b_meta),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .windowed_sample_o (windowed_sample_o),
    .frame_end_o       (frame_end_o)
  );

endmodule

`default_nettype wire

@@ rtl/wfm_checker.sv @@
// ----------------------------------------------------------------------------
// Window function multiplier checker
// Port-level assertions on item flow and frame marking, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wfm_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              cfg_we_i,
  input wire logic [wfm_pkg::IDX_W-1:0]         cfg_index_i,
  input wire logic [wfm_pkg::CFG_W-1:0]         cfg_data_i,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic signed [SAMPLE_BITS-1:0]     sample_in_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic signed [wfm_pkg::OUT_W-1:0]  windowed_sample_o,
  input wire logic                              frame_end_o
);

  import wfm_pkg::*;

  // Queue, four pipeline stages and the output register.
  localparam int unsigned CAPACITY = 7;
  localparam int unsigned OC_W     = 4;

  logic [OC_W-1:0] outstanding_q;
  logic [FL_W-1:0] len_q;
  logic            in_acc, out_acc;
  logic signed [SAMPLE_BITS-1:0] unused_sample;

  assign in_acc        = in_valid_i && in_ready_o;
  assign out_acc       = out_valid_o && out_ready_i;
  assign unused_sample = sample_in_i;

  // Items accepted but not yet delivered, and a shadow of the frame length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
      len_q         <= FL_W'(512);
    end else begin
      if (in_acc && !out_acc) begin
        outstanding_q <= outstanding_q + OC_W'(1);
      end else if (out_acc && !in_acc) begin
        outstanding_q <= outstanding_q - OC_W'(1);
      end
      if (cfg_we_i && cfg_index_i == REG_FRAME_LENGTH) begin
        len_q <= cfg_data_i[FL_W-1:0];
      end
    end
  end

  // A result that is not taken stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(windowed_sample_o)
      && $stable(frame_end_o))
    else $error("result changed while stalled");

  // No result without an item in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outstanding_q != '0)
    else $error("result without an accepted item");

  // Buffering never holds more items than the design has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= OC_W'(CAPACITY))
    else $error("more items in flight than the design can hold");

  // A one-sample frame marks every result as the frame end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (len_q == FL_W'(0) || len_q == FL_W'(1)) |-> frame_end_o)
    else $error("frame end missing with a one-sample frame");

endmodule

bind window_function_multiplier wfm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_wfm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .cfg_we_i          (cfg_we_i),
  .cfg_index_i       (cfg_index_i),
  .cfg_data_i        (cfg_data_i),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .sample_in_i       (sample_in_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .windowed_sample_o (windowed_sample_o),
  .frame_end_o       (frame_end_o)
);

`default_nettype wire

@@ test/windowed_sample_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed sample checker
// Watches the configuration port and both item channels of the window
// function multiplier. It keeps its own copy of the window settings, sample
// position and phase, computes the windowed sample and frame flag of every
// accepted input item, and compares each output item with the oldest
// prediction.
// ----------------------------------------------------------------------------

module windowed_sample_checker
  import wfm_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [IDX_W-1:0]              cfg_index_i,
  input  wire logic [CFG_W-1:0]              cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_o,
  input  wire logic signed [15:0]            sample_in_i,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  input  wire logic signed [OUT_W-1:0]       windowed_sample_o,
  input  wire logic                          frame_end_o,
  output int                                 mismatches_o,
  output int                                 pending_o,
  output int                                 checked_o,
  output int                                 frames_o
);

  // Fixed-point constants of the window arithmetic.
  localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
  localparam int          QUARTER_TURN  = 256;
  localparam int          TURN_BITS     = 10;
  localparam longint      UNITY_Q14     = 16384;
  localparam longint      HALF_LSB_Q14  = 8192;
  localparam int          MAX_FRAME_LEN = 4096;
  localparam longint      SAT_HIGH      = 262143;
  localparam longint      SAT_LOW       = -262144;
  localparam int          REPORT_LIMIT  = 10;

  // Window coefficients in Q14.
  localparam longint HANN_C       = 8192;
  localparam longint HAMMING_C0   = 8847;
  localparam longint HAMMING_C1   = 7537;
  localparam longint BLACKMAN_C0  = 6881;
  localparam longint BLACKMAN_C1  = 8192;
  localparam longint BLACKMAN_C2  = 1311;
  localparam longint FLATTOP_C1   = 31621;
  localparam longint FLATTOP_C2   = 21135;
  localparam longint FLATTOP_C3   = 6357;
  localparam longint FLATTOP_C4   = 524;

  typedef struct packed {
    logic signed [OUT_W-1:0] sample;
    logic                    frame_end;
  } windowed_item_t;

  logic [14:0]    quarter_cos [0:QUARTER_TURN];
  windowed_item_t expected_items [$];

  logic [KIND_W-1:0]  window_kind;
  logic [FL_W-1:0]    frame_length;
  logic [PHASE_W-1:0] phase_step;
  logic [11:0]        sample_position;
  logic [PHASE_W-1:0] phase_acc;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int frame_count;

  assign mismatches_o = mismatch_count;
  assign pending_o    = pending_count;
  assign checked_o    = checked_count;
  assign frames_o     = frame_count;

  // Quarter-wave cosine table from a Q2.30 Taylor series, rounded to Q14.
  initial begin
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      v;
    for (int i = 0; i <= QUARTER_TURN; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / QUARTER_TURN;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int k = 1; k <= 12; k++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      v = (sum > 0) ? longint'((64'(sum) + 64'd32768) >> 16) : 64'sd0;
      if (v > UNITY_Q14) begin
        v = UNITY_Q14;
      end
      quarter_cos[i] = 15'(v);
    end
  end

  // Cosine over a full turn, indexed by the top bits of the phase.
  function automatic longint cos_q14(input logic [PHASE_W-1:0] phase);
    logic [TURN_BITS-1:0] idx;
    logic [7:0]           off;
    idx = phase[PHASE_W-1 -: TURN_BITS];
    off = idx[7:0];
    case (idx[TURN_BITS-1 -: 2])
      2'd0:    return longint'(quarter_cos[off]);
      2'd1:    return -longint'(quarter_cos[QUARTER_TURN - int'(off)]);
      2'd2:    return -longint'(quarter_cos[off]);
      default: return longint'(quarter_cos[QUARTER_TURN - int'(off)]);
    endcase
  endfunction

  // Window value in Q14; the cosine sum is rounded half up from Q28.
  function automatic longint window_q14(input logic [KIND_W-1:0] kind,
                                        input logic [PHASE_W-1:0] phase);
    longint c1;
    longint c2;
    longint c3;
    longint c4;
    longint base;
    longint sum;
    c1 = cos_q14(phase);
    c2 = cos_q14(32'(phase * 32'd2));
    c3 = cos_q14(32'(phase * 32'd3));
    c4 = cos_q14(32'(phase * 32'd4));
    case (kind)
      WIN_HANN: begin
        base = HANN_C;
        sum  = -HANN_C * c1;
      end
      WIN_HAMMING: begin
        base = HAMMING_C0;
        sum  = -HAMMING_C1 * c1;
      end
      WIN_BLACKMAN: begin
        base = BLACKMAN_C0;
        sum  = -BLACKMAN_C1 * c1 + BLACKMAN_C2 * c2;
      end
      WIN_FLATTOP: begin
        base = UNITY_Q14;
        sum  = -FLATTOP_C1 * c1 + FLATTOP_C2 * c2 - FLATTOP_C3 * c3 + FLATTOP_C4 * c4;
      end
      default: return UNITY_Q14;
    endcase
    return base + ((sum + HALF_LSB_Q14) >>> 14);
  endfunction

  // Sample times window, rounded back to integer and saturated to 19 bits.
  function automatic logic signed [OUT_W-1:0] windowed_value(
    input logic [KIND_W-1:0]  kind,
    input logic [PHASE_W-1:0] phase,
    input logic signed [15:0] sample
  );
    longint y;
    y = (longint'(sample) * window_q14(kind, phase) + HALF_LSB_Q14) >>> 14;
    if (y > SAT_HIGH) begin
      y = SAT_HIGH;
    end
    if (y < SAT_LOW) begin
      y = SAT_LOW;
    end
    return OUT_W'(y);
  endfunction

  // Track settings and frame state, predict on input items, compare outputs.
  always @(posedge clk_i or negedge rst_ni) begin
    windowed_item_t got;
    windowed_item_t want;
    int             eff_len;
    logic           frame_done;
    if (!rst_ni) begin
      expected_items.delete();
      window_kind     = WIN_HANN;
      frame_length    = 13'd512;
      phase_step      = 32'd8388608;
      sample_position = '0;
      phase_acc       = '0;
      mismatch_count  = 0;
      pending_count   = 0;
      checked_count   = 0;
      frame_count     = 0;
    end else begin
      // Output item against the oldest prediction.
      if (out_valid_o && out_ready_i) begin
        got.sample    = windowed_sample_o;
        got.frame_end = frame_end_o;
        checked_count++;
        if (frame_end_o === 1'b1) begin
          frame_count++;
        end
        if (expected_items.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] unexpected output item: sample %0d frame_end %b",
                     $realtime, got.sample, got.frame_end);
          end
        end else begin
          want = expected_items.pop_front();
          if (got.sample !== want.sample || got.frame_end !== want.frame_end) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("[%0t] mismatch: sample exp %0d got %0d, frame_end exp %b got %b",
                       $realtime, want.sample, got.sample, want.frame_end, got.frame_end);
            end
          end
        end
      end

      // Input item: predict, then advance position and phase.
      if (in_valid_i && in_ready_o) begin
        eff_len = int'(frame_length);
        if (eff_len == 0) begin
          eff_len = 1;
        end
        if (eff_len > MAX_FRAME_LEN) begin
          eff_len = MAX_FRAME_LEN;
        end
        frame_done     = int'(sample_position) >= eff_len - 1;
        want.sample    = windowed_value(window_kind, phase_acc, sample_in_i);
        want.frame_end = frame_done;
        expected_items.push_back(want);
        if (frame_done) begin
          sample_position = '0;
          phase_acc       = '0;
        end else begin
          sample_position = sample_position + 12'd1;
          phase_acc       = phase_acc + phase_step;
        end
      end

      // Register writes; they never restart the frame.
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WINDOW_KIND:  window_kind  = cfg_data_i[KIND_W-1:0];
          REG_FRAME_LENGTH: frame_length = cfg_data_i[FL_W-1:0];
          REG_PHASE_STEP:   phase_step   = cfg_data_i;
          default: ;
        endcase
      end

      pending_count = expected_items.size();
    end
  end

endmodule

@@ test/tb_window_function_multiplier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window function multiplier testbench
// Drives samples through the window function multiplier under a series of
// window settings: a short directed set for the extreme samples, every
// window kind and the odd frame lengths, then random bursts under three
// pacing mixes. A separate checker predicts and compares every item.
// ----------------------------------------------------------------------------

module tb_window_function_multiplier;
  import wfm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNLISTED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNLISTED_LAST  = 3'd7;
  localparam int ITEMS_PER_MIX = 150;
  localparam int SETTLE_CYCLES = 20;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [IDX_W-1:0]        cfg_index_i;
  logic [CFG_W-1:0]        cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [15:0]      sample_in_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [OUT_W-1:0] windowed_sample_o;
  logic                    frame_end_o;

  int mismatches;
  int pending_results;
  int checked_results;
  int frame_ends;

  int sender_idle_pct;
  int receiver_stall_pct;
  int samples_sent;
  int settings_used;

  window_function_multiplier u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_in_i       (sample_in_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .windowed_sample_o (windowed_sample_o),
    .frame_end_o       (frame_end_o)
  );

  windowed_sample_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_in_i       (sample_in_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .windowed_sample_o (windowed_sample_o),
    .frame_end_o       (frame_end_o),
    .mismatches_o      (mismatches),
    .pending_o         (pending_results),
    .checked_o         (checked_results),
    .frames_o          (frame_ends)
  );

  // Clock with a 10 ns period.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stalls at random on the falling edge.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Offers one sample after a random idle stretch and waits until it is taken.
  task automatic send_sample(input logic signed [15:0] value);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= value;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // Holds the input back until every predicted output item has come out.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (pending_results != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Writes all three registers once the block has gone quiet.
  task automatic configure(input logic [CFG_W-1:0] kind_word,
                           input logic [CFG_W-1:0] length_word,
                           input logic [CFG_W-1:0] step_word);
    hold_until_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_WINDOW_KIND;
    cfg_data_i  <= kind_word;
    @(negedge clk_i);
    cfg_index_i <= REG_FRAME_LENGTH;
    cfg_data_i  <= length_word;
    @(negedge clk_i);
    cfg_index_i <= REG_PHASE_STEP;
    cfg_data_i  <= step_word;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Stimulus: reset, directed cases, then random bursts under three pacings.
  initial begin
    int                 burst;
    int                 eff_len;
    logic [CFG_W-1:0]   kind_word;
    logic [CFG_W-1:0]   length_word;
    logic [CFG_W-1:0]   step_word;
    logic signed [15:0] value;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = REG_WINDOW_KIND;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    sample_in_i        = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    samples_sent       = 0;
    settings_used      = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Settings straight out of reset: Hann over 512 samples.
    send_sample(16'sh7FFF);
    send_sample(-16'sd1234);

    // Rectangular, four-sample frames, full-scale samples.
    configure(32'(WIN_RECT), 32'd4, 32'h4000_0000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shFFFF);
    send_sample(16'sh0001);

    // Flat-top over a full eight-sample frame reaches its largest gain.
    configure(32'(WIN_FLATTOP), 32'd8, 32'h2000_0000);
    for (int i = 0; i < 8; i++) begin
      send_sample(i[0] ? 16'sh7FFF : 16'sh8000);
    end

    // Unlisted window code, zero frame length and an unrelated phase step.
    configure(32'(KIND_UNLISTED_LAST), 32'd0, 32'hFFFF_FFFF);
    send_sample(16'sh5A5A);
    send_sample(16'shA5A5);

    // Hamming with a frame length beyond the largest frame.
    configure(32'(WIN_HAMMING), 32'h0000_1FFF, 32'h0010_0000);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);

    // Blackman, then the frame shrinks below the current position.
    configure(32'(WIN_BLACKMAN), 32'd16, 32'h1000_0000);
    for (int i = 0; i < 6; i++) begin
      send_sample(16'sh7FFF);
    end
    configure(32'(WIN_BLACKMAN), 32'd3, 32'h1000_0000);
    send_sample(16'sh8000);
    send_sample(16'sh4000);

    // Random settings and samples under each pacing mix.
    for (int mix = 0; mix < 3; mix++) begin
      case (mix)
        0: begin
          sender_idle_pct    = 23;
          receiver_stall_pct = 60;
        end
        1: begin
          sender_idle_pct    = 60;
          receiver_stall_pct = 23;
        end
        default: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
      endcase
      for (int left = ITEMS_PER_MIX; left > 0; left -= burst) begin
        if ($urandom_range(0, 9) < 9) begin
          kind_word = 32'($urandom_range(WIN_RECT, WIN_FLATTOP));
        end else begin
          kind_word = 32'($urandom_range(KIND_UNLISTED_FIRST, KIND_UNLISTED_LAST));
        end
        case ($urandom_range(0, 19))
          0:       length_word = 32'd0;
          1:       length_word = 32'd1;
          2:       length_word = 32'd4096;
          3:       length_word = 32'($urandom_range(4097, 8191));
          default: length_word = 32'($urandom_range(2, 40));
        endcase
        eff_len = int'(length_word[FL_W-1:0]);
        if (eff_len == 0) begin
          eff_len = 1;
        end
        if (eff_len > 4096) begin
          eff_len = 4096;
        end
        case ($urandom_range(0, 9))
          0:       step_word = $urandom();
          1:       step_word = 32'hFFFF_FFFF;
          2:       step_word = 32'd0;
          default: step_word = 32'((((64'd1 << 33) / 64'(eff_len)) + 64'd1) >> 1);
        endcase
        // Upper bits beyond each register's width are sometimes set too.
        if ($urandom_range(0, 3) == 0) begin
          kind_word   = kind_word | ($urandom() & ~32'h7);
          length_word = length_word | ($urandom() & 32'hFFFF_E000);
        end
        configure(kind_word, length_word, step_word);

        burst = $urandom_range(10, 50);
        if (burst > left) begin
          burst = left;
        end
        for (int i = 0; i < burst; i++) begin
          case ($urandom_range(0, 9))
            0:       value = 16'sh7FFF;
            1:       value = 16'sh8000;
            2:       value = ($urandom_range(0, 1) != 0) ? 16'sh0001 : 16'shFFFF;
            default: value = 16'($urandom());
          endcase
          send_sample(value);
          if ($urandom_range(0, 99) < 3) begin
            hold_until_drained();
          end
        end
      end
    end

    // Drain, let the pipeline settle, then report.
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("Sent %0d samples under %0d window settings; checked %0d results, %0d frame ends.",
             samples_sent, settings_used, checked_results, frame_ends);
    $display("Pacing covered 23/60 and 60/23 percent idle mixes and back-to-back streaming.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
